@@ rtl/mfva_pkg.sv @@
package mfva_pkg;

    localparam int NUM_VOICES_DEF = 9;

    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

    localparam logic [7:0] ADDR_RHYTHM  = 8'h0E;
    localparam logic [7:0] ADDR_FNUM_LO = 8'h10;
    localparam logic [7:0] ADDR_FNUM_HI = 8'h20;
    localparam logic [7:0] ADDR_INSTR   = 8'h30;

    localparam logic [7:0] KEY_ON_BIT   = 8'h10;

    // floor(n / 12) == (n * 43) >> 9 for every 7-bit n
    localparam logic [12:0] DIV12_MUL   = 13'd43;
    localparam int          DIV12_SHIFT = 9;
    localparam logic [3:0]  SEMITONES   = 4'd12;

    localparam logic REG_VOLUME = 1'b0;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] note_number;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic [3:0] instrument;
        logic [6:0] note;
        logic       busy;
    } t_voice;

    typedef struct packed {
        logic       is_on;
        logic [3:0] instrument;
        logic [6:0] note;
    } t_match_req;

    function automatic logic [8:0] fnum_lookup(input logic [3:0] pitch);
        logic [8:0] fn;
        case (pitch)
            4'd0:    fn = 9'd172;
            4'd1:    fn = 9'd181;
            4'd2:    fn = 9'd192;
            4'd3:    fn = 9'd204;
            4'd4:    fn = 9'd216;
            4'd5:    fn = 9'd229;
            4'd6:    fn = 9'd242;
            4'd7:    fn = 9'd257;
            4'd8:    fn = 9'd272;
            4'd9:    fn = 9'd288;
            4'd10:   fn = 9'd305;
            4'd11:   fn = 9'd323;
            default: fn = 9'd0;
        endcase
        return fn;
    endfunction

endpackage

@@ rtl/mfva_voice_table.sv @@
module mfva_voice_table #(
    parameter int NUM_VOICES = mfva_pkg::NUM_VOICES_DEF,
    parameter int IW         = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IW-1:0]    i_rd_idx,
    output mfva_pkg::t_voice o_rd_voice,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_idx,
    input  mfva_pkg::t_voice i_wr_voice
);
    import mfva_pkg::*;

    t_voice r_voices [NUM_VOICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_voices[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_voices[i_wr_idx] <= i_wr_voice;
        end
    end

    assign o_rd_voice = r_voices[i_rd_idx];

endmodule

@@ rtl/mfva_match_unit.sv @@
module mfva_match_unit (
    input  mfva_pkg::t_voice     i_voice,
    input  mfva_pkg::t_match_req i_req,
    output logic                 o_hit
);
    import mfva_pkg::*;

    logic w_same;

    // note-on wants a free voice, note-off a busy one with same note and instrument
    assign w_same = (i_voice.note == i_req.note) && (i_voice.instrument == i_req.instrument);
    assign o_hit  = i_req.is_on ? !i_voice.busy : (i_voice.busy && w_same);

endmodule

@@ rtl/midi_fm_voice_allocator.sv @@
// note-on: accept, scan for a free voice (else steal voice 0), then emit the rhythm, fnum-lo,
//   fnum-hi and instrument writes; note-off: accept, scan for a match, then emit the key-off write
// one item at a time (o_in_stall is high outside idle); one voice scanned per cycle and one write
//   per cycle while the output is not stalled; unmatched note-offs and other statuses emit nothing
// each output write waits in a single output register while o_out_valid and i_out_stall are high
// synchronous active-low reset clears every voice, the volume register and all control state
module midi_fm_voice_allocator #(
    parameter int NUM_VOICES = mfva_pkg::NUM_VOICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mfva_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mfva_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mfva_pkg::*;

    localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;
    typedef enum logic [1:0] {W_RHYTHM, W_FNUM_LO, W_FNUM_HI, W_INSTR} t_wr_step;

    t_state     r_state;
    t_wr_step   r_wr;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_voice;
    logic       r_is_on;
    logic [3:0] r_instr;
    logic [6:0] r_note;
    logic [3:0] r_quot;
    logic [3:0] r_volume;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_accept;
    logic [3:0] w_cmd;
    logic [12:0] w_prod;
    logic       w_hit;
    logic       w_scan_end;
    logic       w_slot_free;
    logic       w_tbl_wr;
    logic [IW-1:0] w_tbl_idx;
    t_voice     w_rd_voice;
    t_voice     w_wr_voice;
    t_match_req w_req;
    logic [6:0] w_pitch;
    logic [8:0] w_fnum;
    logic [7:0] w_voice8;
    t_out_item  w_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VOLUME) ? {28'd0, r_volume} : 32'd0;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_cmd    = i_in_item.status_byte[7:4];
    assign w_prod   = 13'(i_in_item.note_number) * DIV12_MUL;

    assign w_req = '{is_on: r_is_on, instrument: r_instr, note: r_note};

    mfva_voice_table #(
        .NUM_VOICES (NUM_VOICES),
        .IW         (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd_voice (w_rd_voice),
        .i_wr_en    (w_tbl_wr),
        .i_wr_idx   (w_tbl_idx),
        .i_wr_voice (w_wr_voice)
    );

    mfva_match_unit u_match (
        .i_voice (w_rd_voice),
        .i_req   (w_req),
        .o_hit   (w_hit)
    );

    assign w_scan_end = (r_idx == IW'(NUM_VOICES - 1));
    assign w_tbl_wr   = (r_state == S_SCAN) && (w_hit || (w_scan_end && r_is_on));
    assign w_tbl_idx  = w_hit ? r_idx : '0;
    assign w_wr_voice = r_is_on ? '{instrument: r_instr, note: r_note, busy: 1'b1}
                                : '{instrument: w_rd_voice.instrument,
                                    note: w_rd_voice.note, busy: 1'b0};

    assign w_pitch  = r_note - 7'(r_quot * SEMITONES);
    assign w_fnum   = fnum_lookup(w_pitch[3:0]);
    assign w_voice8 = 8'(r_voice);

    always_comb begin
        w_item = '0;
        if (!r_is_on) begin
            w_item = '{reg_address: ADDR_FNUM_HI + w_voice8, reg_data: 8'd0, last_write: 1'b1};
        end else begin
            case (r_wr)
                W_RHYTHM: begin
                    w_item = '{reg_address: ADDR_RHYTHM, reg_data: 8'd0, last_write: 1'b0};
                end
                W_FNUM_LO: begin
                    w_item = '{reg_address: ADDR_FNUM_LO + w_voice8,
                               reg_data: w_fnum[7:0], last_write: 1'b0};
                end
                W_FNUM_HI: begin
                    w_item = '{reg_address: ADDR_FNUM_HI + w_voice8,
                               reg_data: KEY_ON_BIT | {4'd0, r_quot[2:0], w_fnum[8]},
                               last_write: 1'b0};
                end
                W_INSTR: begin
                    w_item = '{reg_address: ADDR_INSTR + w_voice8,
                               reg_data: {r_instr, r_volume}, last_write: 1'b1};
                end
                default: begin
                    w_item = '0;
                end
            endcase
        end
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr        <= W_RHYTHM;
            r_idx       <= '0;
            r_voice     <= '0;
            r_is_on     <= 1'b0;
            r_volume    <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_VOLUME)) begin
                r_volume <= pwdata[3:0];
            end

            if ((r_state == S_EMIT) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_cmd == CMD_NOTE_ON || w_cmd == CMD_NOTE_OFF)) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                        r_wr    <= W_RHYTHM;
                        r_is_on <= (w_cmd == CMD_NOTE_ON);
                        r_instr <= i_in_item.status_byte[3:0];
                        r_note  <= i_in_item.note_number;
                        r_quot  <= w_prod[DIV12_SHIFT +: 4];
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_voice <= r_idx;
                        r_state <= S_EMIT;
                    end else if (w_scan_end) begin
                        r_voice <= '0;
                        r_state <= r_is_on ? S_EMIT : S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out <= w_item;
                        if (w_item.last_write) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_wr <= t_wr_step'(r_wr + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ verif/tb_midi_fm_voice_allocator.sv @@
`timescale 1ns / 1ps

module tb_midi_fm_voice_allocator;
    import mfva_pkg::*;

    localparam int NV            = NUM_VOICES_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 72;
    localparam int NUM_PHASES    = 5;
    localparam int LONG_HOLD     = 300;

    localparam logic [2:0] VOLUME_ADDR = 3'({REG_VOLUME, 2'b00});
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    localparam logic [8:0] FNUM_BY_PITCH [12] = '{
        9'd172, 9'd181, 9'd192, 9'd204, 9'd216, 9'd229,
        9'd242, 9'd257, 9'd272, 9'd288, 9'd305, 9'd323
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    class fm_write_tracker;
        t_voice     voices[NV];
        logic [3:0] volume;
        t_out_item  expected_writes[$];
        int errors;
        int n_on;
        int n_steal;
        int n_off_hit;
        int n_off_miss;
        int n_other;
        int n_checked;

        function new();
            foreach (voices[i]) voices[i] = '0;
            volume = '0;
        endfunction

        function void push_write(logic [7:0] addr, logic [7:0] data, logic last);
            t_out_item w;
            w.reg_address = addr;
            w.reg_data    = data;
            w.last_write  = last;
            expected_writes.push_back(w);
        endfunction

        function void write_config(logic [2:0] addr, logic [31:0] data);
            if (addr == VOLUME_ADDR) begin
                volume = data[3:0];
            end
        endfunction

        // returns how many chip writes the item causes
        function int apply_event(t_in_item it);
            logic [3:0] cmd;
            logic [3:0] instr;
            logic [8:0] fn;
            logic [2:0] oct;
            int         v;
            bit         found;
            cmd   = it.status_byte[7:4];
            instr = it.status_byte[3:0];
            found = 0;
            v     = 0;
            if (cmd == CMD_NOTE_ON) begin
                for (int i = 0; i < NV; i++) begin
                    if (!found && !voices[i].busy) begin
                        v     = i;
                        found = 1;
                    end
                end
                if (!found) n_steal++;
                n_on++;
                voices[v].instrument = instr;
                voices[v].note       = it.note_number;
                voices[v].busy       = 1'b1;
                fn  = FNUM_BY_PITCH[it.note_number % 7'd12];
                oct = 3'(it.note_number / 7'd12);
                push_write(ADDR_RHYTHM, 8'h00, 1'b0);
                push_write(ADDR_FNUM_LO + 8'(v), fn[7:0], 1'b0);
                push_write(ADDR_FNUM_HI + 8'(v), KEY_ON_BIT | {4'b0000, oct, fn[8]}, 1'b0);
                push_write(ADDR_INSTR + 8'(v), {instr, volume}, 1'b1);
                return 4;
            end
            if (cmd == CMD_NOTE_OFF) begin
                for (int i = 0; i < NV; i++) begin
                    if (!found && voices[i].busy && voices[i].note == it.note_number &&
                        voices[i].instrument == instr) begin
                        voices[i].busy = 1'b0;
                        push_write(ADDR_FNUM_HI + 8'(i), 8'h00, 1'b1);
                        found = 1;
                    end
                end
                if (found) begin
                    n_off_hit++;
                    return 1;
                end
                n_off_miss++;
                return 0;
            end
            n_other++;
            return 0;
        endfunction

        function void check_write(t_out_item got);
            t_out_item want;
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write addr %h data %h last %b", $time,
                         got.reg_address, got.reg_data, got.last_write);
                return;
            end
            want = expected_writes.pop_front();
            n_checked++;
            if (got.reg_address !== want.reg_address) begin
                errors++;
                $display("%0t: reg_address expected %h actual %h", $time,
                         want.reg_address, got.reg_address);
            end
            if (got.reg_data !== want.reg_data) begin
                errors++;
                $display("%0t: reg_data expected %h actual %h (addr %h)", $time,
                         want.reg_data, got.reg_data, want.reg_address);
            end
            if (got.last_write !== want.last_write) begin
                errors++;
                $display("%0t: last_write expected %b actual %b (addr %h)", $time,
                         want.last_write, got.last_write, want.reg_address);
            end
        endfunction

        function void check_readback(logic [31:0] rd);
            if (rd !== 32'(volume)) begin
                errors++;
                $display("%0t: volume readback expected %h actual %h", $time,
                         32'(volume), rd);
            end
        endfunction
    endclass

    fm_write_tracker sb;
    bit rst_done;
    bit tx_calm;
    bit rx_calm;
    int rx_hold_req;
    int cycles;
    int settings_seen;

    midi_fm_voice_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_event(input t_in_item it, output int nres);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        nres = sb.apply_event(it);
    endtask

    task automatic send_pair(input logic [7:0] status, input logic [6:0] note);
        t_in_item it;
        int       nres;
        it.status_byte = status;
        it.note_number = note;
        send_event(it, nres);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_config(addr, data);
    endtask

    task automatic reg_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.check_readback(prdata);
    endtask

    task automatic set_volume(input logic [3:0] vol);
        reg_write(VOLUME_ADDR, {28'($urandom() >> 4), vol});
        reg_read(VOLUME_ADDR);
        reg_write(UNUSED_ADDR, $urandom());
        reg_read(VOLUME_ADDR);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_seen++;
    endtask

    function automatic t_in_item random_event(int on_pct);
        t_in_item it;
        int       r;
        int       v;
        int       busy_idx[$];
        r = $urandom_range(0, 99);
        for (int i = 0; i < NV; i++) begin
            if (sb.voices[i].busy) busy_idx.push_back(i);
        end
        if (r < on_pct) begin
            it.status_byte = {CMD_NOTE_ON, 4'($urandom_range(0, 15))};
            if ($urandom_range(0, 3) == 0) begin
                it.note_number = 7'(60 + $urandom_range(0, 2));
            end else begin
                it.note_number = 7'($urandom_range(0, 127));
            end
        end else if (r < on_pct + 30 && busy_idx.size() > 0) begin
            v = busy_idx[$urandom_range(0, busy_idx.size() - 1)];
            it.status_byte = {CMD_NOTE_OFF, sb.voices[v].instrument};
            it.note_number = sb.voices[v].note;
        end else if (r < 92) begin
            it.status_byte = {CMD_NOTE_OFF, 4'($urandom_range(0, 15))};
            if (busy_idx.size() > 0 && $urandom_range(0, 1) == 1) begin
                v = busy_idx[$urandom_range(0, busy_idx.size() - 1)];
                it.note_number = sb.voices[v].note;
            end else begin
                it.note_number = 7'($urandom_range(0, 127));
            end
        end else begin
            it.status_byte = 8'($urandom_range(0, 255));
            it.note_number = 7'($urandom_range(0, 127));
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int on_pct);
        int nres;
        for (int k = 0; k < count; k++) begin
            send_event(random_event(on_pct), nres);
        end
    endtask

    // output side: per-item stall draw plus an occasional long hold-off
    initial begin
        int stall_left;
        int hold_left;
        int holds_taken;
        stall_left  = 0;
        hold_left   = 0;
        holds_taken = 0;
        i_out_stall <= 1'b0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_write(o_out_item);
                stall_left = rx_calm ? 0 : $urandom_range(0, 19);
            end
            if (rx_hold_req != holds_taken) begin
                hold_left   = LONG_HOLD;
                holds_taken = rx_hold_req;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d writes still expected", cycles,
                 sb.expected_writes.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [3:0] phase_vol [NUM_PHASES];
        int         phase_on  [NUM_PHASES];
        int         nres;
        phase_vol = '{4'hF, 4'h0, 4'h7, 4'($urandom_range(0, 15)), 4'h1};
        phase_on  = '{50, 65, 45, 55, 40};
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done  = 1;
        @(posedge i_clk);

        reg_read(VOLUME_ADDR);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_seen = 1;

        // fill all voices, steal voice 0, extreme notes and octaves above 7; then note-offs, other statuses
        send_pair({CMD_NOTE_ON, 4'h0}, 7'd0);
        send_pair({CMD_NOTE_ON, 4'hF}, 7'd127);
        send_pair({CMD_NOTE_ON, 4'h5}, 7'd96);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd11);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd71);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd100);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd50);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd60);
        send_pair({CMD_NOTE_ON, 4'h3}, 7'd60);
        send_pair({CMD_NOTE_ON, 4'h1}, 7'd30);
        send_pair({CMD_NOTE_OFF, 4'h0}, 7'd0);
        send_pair({CMD_NOTE_OFF, 4'h1}, 7'd30);
        send_pair({CMD_NOTE_OFF, 4'h3}, 7'd60);
        send_pair({CMD_NOTE_OFF, 4'h2}, 7'd60);
        send_pair({CMD_NOTE_OFF, 4'hF}, 7'd127);
        send_pair(8'h00, 7'd5);
        send_pair(8'hFF, 7'd127);
        send_pair(8'hA9, 7'd64);
        send_pair(8'h7F, 7'd0);
        send_pair({CMD_NOTE_ON, 4'hA}, 7'd45);
        send_pair({CMD_NOTE_ON, 4'h7}, 7'd119);
        send_pair({CMD_NOTE_OFF, 4'h3}, 7'd60);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_volume(phase_vol[p]);
            if (p == 1) begin
                run_random(30, phase_on[p]);
                // long output hold-off while input keeps coming
                rx_hold_req++;
                tx_calm     = 1;
                for (int k = 0; k < 24; k++) begin
                    send_event(random_event(70), nres);
                end
                tx_calm = 0;
                wait_drained();
                run_random(PHASE_ITEMS - 54, phase_on[p]);
            end else if (p == 2) begin
                tx_calm = 1;
                rx_calm = 1;
                run_random(PHASE_ITEMS / 2, phase_on[p]);
                tx_calm = 0;
                rx_calm = 0;
                run_random(PHASE_ITEMS / 2, phase_on[p]);
            end else begin
                run_random(PHASE_ITEMS, phase_on[p]);
            end
            wait_drained();
        end

        if (sb.expected_writes.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected writes never arrived", $time,
                     sb.expected_writes.size());
        end
        $display("note-ons %0d (voice steals %0d), note-offs freeing a voice %0d, unmatched %0d",
                 sb.n_on, sb.n_steal, sb.n_off_hit, sb.n_off_miss);
        $display("other statuses %0d, chip writes checked %0d, volume settings %0d",
                 sb.n_other, sb.n_checked, settings_seen);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
